// ===== rtl/srfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srfr_pkg
// Types and codes shared by the servo response frame receiver modules.
// ----------------------------------------------------------------------------
package srfr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int JOBQ_DEPTH = 2;

    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CHECKSUM = 3'd1;
    localparam logic [2:0] ST_SIZE     = 3'd2;
    localparam logic [2:0] ST_ID       = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] id_byte;
        logic [7:0] size_field;
        logic [7:0] stat_byte;
        logic [7:0] content_byte;
        logic [5:0] content_index;
        logic       has_content;
        logic       last;
    } out_item_t;

    // one finished frame or error, as handed to the emitter
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] id_byte;
        logic [7:0] size_field;
        logic [7:0] stat_byte;
        logic       run;        // good frame with content in the store
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

endpackage
`default_nettype wire

// ===== rtl/servo_response_frame_receiver_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// servo_response_frame_receiver_unit
// Serial-bus servo response frame receiver with inverted-sum checksum.
// ----------------------------------------------------------------------------
// A begin item arms the receiver and restarts the tick timeout; byte items
// are then parsed as header, id, size, status, content and checksum, and
// tick items count toward the timeout. An input item is taken while the job
// queue has room and the store is not held. An error or timeout result
// reaches the output through the job queue and then the output register.
// A good frame with content is delivered as one result per content byte,
// each through a content store read and then the output register; input is
// held off from the good frame's checksum byte until its last content
// result is taken, since the store holds one frame. The content store
// needs no clearing after reset.
module servo_response_frame_receiver_unit #(
    parameter int MAX_FRAME = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire srfr_pkg::in_item_t             s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output srfr_pkg::out_item_t                 m_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [srfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                    cfg_data
);
    import srfr_pkg::*;

    localparam int ADDR_W = $clog2(MAX_FRAME);

    job_push_t         push;
    job_t              q_head;
    logic              q_full, q_empty, q_pop;
    logic              run_done;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    srfr_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .q_full    (q_full),
        .run_done  (run_done),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    srfr_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srfr_job_q u_jobq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .head    (q_head)
    );

    srfr_back #(.MAX_FRAME(MAX_FRAME)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .run_done  (run_done),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// ===== rtl/srfr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srfr_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module srfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/srfr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srfr_front
// Input side: config registers, frame parser, timeout, content store writes.
// Pushes one job per finished frame or error into the job queue.
// ----------------------------------------------------------------------------
module srfr_front #(
    parameter int MAX_FRAME = 64,
    localparam int ADDR_W = $clog2(MAX_FRAME)
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire srfr_pkg::in_item_t               s_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [srfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [15:0]                      cfg_data,
    output srfr_pkg::job_push_t                   push,
    input  wire logic                             q_full,
    input  wire logic                             run_done,
    output logic                                  ram_we,
    output logic      [ADDR_W-1:0]                ram_waddr,
    output logic      [7:0]                       ram_wdata
);
    import srfr_pkg::*;

    localparam logic [7:0] SIZE_MAX = 8'(MAX_FRAME - 5);

    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_ID      = 6'b000010,
        PH_SIZE    = 6'b000100,
        PH_STAT    = 6'b001000,
        PH_CONTENT = 6'b010000,
        PH_CHECK   = 6'b100000
    } phase_t;

    logic [15:0]       header_reg, header_next;
    logic [7:0]        max_id_reg, max_id_next;
    logic [15:0]       timeout_reg, timeout_next;
    phase_t            phase_reg, phase_next;
    logic              armed_reg, armed_next;
    logic              first_reg, first_next;
    logic [7:0]        id_reg, id_next;
    logic [7:0]        size_reg, size_next;
    logic [7:0]        stat_reg, stat_next;
    logic [ADDR_W-1:0] count_reg, count_next;
    logic [7:0]        sum_reg, sum_next;
    logic [15:0]       tick_reg, tick_next;
    logic              lock_reg, lock_next;

    logic        s_fire;
    logic [15:0] tick_inc;
    logic [7:0]  clen;
    logic [7:0]  b;

    assign s_ready   = !lock_reg && !q_full;
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign b         = s_data.rx_byte;
    assign tick_inc  = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
    assign clen      = size_reg - 8'd2;
    assign ram_waddr = count_reg;
    assign ram_wdata = b;

    always_comb begin
        header_next  = header_reg;
        max_id_next  = max_id_reg;
        timeout_next = timeout_reg;
        phase_next   = phase_reg;
        armed_next   = armed_reg;
        first_next   = first_reg;
        id_next      = id_reg;
        size_next    = size_reg;
        stat_next    = stat_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        tick_next    = tick_reg;
        push         = '0;
        push.job.id_byte    = id_reg;
        push.job.size_field = size_reg;
        push.job.stat_byte  = stat_reg;
        ram_we       = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_HEADER:  header_next  = cfg_data;
                CFG_MAX_ID:  max_id_next  = cfg_data[7:0];
                CFG_TIMEOUT: timeout_next = cfg_data;
                default: ;
            endcase
        end

        if (s_fire) begin
            case (s_data.req_type)
                REQ_BEGIN: begin
                    armed_next = 1'b1;
                    phase_next = PH_HUNT;
                    first_next = 1'b0;
                    id_next    = '0;
                    size_next  = '0;
                    stat_next  = '0;
                    count_next = '0;
                    sum_next   = '0;
                    tick_next  = '0;
                end
                REQ_BYTE: begin
                    if (armed_reg) begin
                        case (phase_reg)
                            PH_HUNT: begin
                                if (!first_reg) begin
                                    first_next = (b == header_reg[7:0]);
                                end else begin
                                    first_next = 1'b0;
                                    if (b == header_reg[15:8]) begin
                                        phase_next = PH_ID;
                                    end
                                end
                            end
                            PH_ID: begin
                                id_next = b;
                                if (b > max_id_reg) begin
                                    push.valid        = 1'b1;
                                    push.job.status   = ST_ID;
                                    push.job.id_byte  = b;
                                    armed_next        = 1'b0;
                                end else begin
                                    sum_next   = b;
                                    phase_next = PH_SIZE;
                                end
                            end
                            PH_SIZE: begin
                                size_next = b;
                                if (b < 8'd2 || b > SIZE_MAX) begin
                                    push.valid          = 1'b1;
                                    push.job.status     = ST_SIZE;
                                    push.job.size_field = b;
                                    armed_next          = 1'b0;
                                end else begin
                                    sum_next   = sum_reg + b;
                                    phase_next = PH_STAT;
                                end
                            end
                            PH_STAT: begin
                                stat_next  = b;
                                sum_next   = sum_reg + b;
                                count_next = '0;
                                phase_next = (size_reg == 8'd2) ? PH_CHECK : PH_CONTENT;
                            end
                            PH_CONTENT: begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                sum_next   = sum_reg + b;
                                if (8'(count_reg) + 8'd1 >= clen) begin
                                    phase_next = PH_CHECK;
                                end
                            end
                            PH_CHECK: begin
                                push.valid = 1'b1;
                                armed_next = 1'b0;
                                if (b != ~sum_reg) begin
                                    push.job.status = ST_CHECKSUM;
                                end else begin
                                    push.job.status = ST_OK;
                                    push.job.run    = (clen != 8'd0);
                                end
                            end
                            default: begin
                                phase_next = PH_HUNT;
                                first_next = 1'b0;
                            end
                        endcase
                    end
                end
                REQ_TICK: begin
                    if (armed_reg) begin
                        tick_next = tick_inc;
                        if (tick_inc >= timeout_reg) begin
                            push.valid      = 1'b1;
                            push.job.status = ST_TIMEOUT;
                            armed_next      = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end

        // the content store is held until its run has been delivered
        lock_next = lock_reg ? !run_done : (push.valid && push.job.run);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg  <= 16'hFFFF;
            max_id_reg  <= 8'd253;
            timeout_reg <= 16'd100;
            phase_reg   <= PH_HUNT;
            armed_reg   <= 1'b0;
            first_reg   <= 1'b0;
            id_reg      <= '0;
            size_reg    <= '0;
            stat_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            tick_reg    <= '0;
            lock_reg    <= 1'b0;
        end else begin
            header_reg  <= header_next;
            max_id_reg  <= max_id_next;
            timeout_reg <= timeout_next;
            phase_reg   <= phase_next;
            armed_reg   <= armed_next;
            first_reg   <= first_next;
            id_reg      <= id_next;
            size_reg    <= size_next;
            stat_reg    <= stat_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            tick_reg    <= tick_next;
            lock_reg    <= lock_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/srfr_job_q.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srfr_job_q
// Short FIFO of jobs between the parser and the emitter.
// ----------------------------------------------------------------------------
module srfr_job_q (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire srfr_pkg::job_push_t push,
    output logic                     full,
    input  wire logic                pop,
    output logic                     empty,
    output srfr_pkg::job_t           head
);
    import srfr_pkg::*;

    localparam int PTR_W = $clog2(JOBQ_DEPTH);
    localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

    job_t             mem_reg [JOBQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en, rd_en;

    assign full  = (count_reg == CNT_W'(JOBQ_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];
    assign wr_en = push.valid;
    assign rd_en = pop;

    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && full && !rd_en)) else $error("job pushed into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && empty)) else $error("job popped from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(JOBQ_DEPTH)) else $error("job queue count overflow");

endmodule
`default_nettype wire

// ===== rtl/srfr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srfr_back
// Emitter: takes jobs from the queue, reads back frame content from the
// store and drives the result channel from an output register.
// ----------------------------------------------------------------------------
module srfr_back #(
    parameter int MAX_FRAME = 64,
    localparam int ADDR_W = $clog2(MAX_FRAME)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_empty,
    input  wire srfr_pkg::job_t      q_head,
    output logic                     q_pop,
    output logic      [ADDR_W-1:0]   ram_raddr,
    input  wire logic [7:0]          ram_rdata,
    output logic                     run_done,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output srfr_pkg::out_item_t      m_data
);
    import srfr_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_FETCH = 4'b0010,
        B_LOAD  = 4'b0100,
        B_SEND  = 4'b1000
    } bstate_t;

    bstate_t           state_reg, state_next;
    job_t              job_reg, job_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    out_item_t         out_reg, out_next;
    logic [7:0]        clen;

    assign clen      = job_reg.size_field - 8'd2;
    assign ram_raddr = idx_reg;
    assign m_valid   = (state_reg == B_SEND);
    assign m_data    = out_reg;

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        out_next   = out_reg;
        q_pop      = 1'b0;
        run_done   = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    job_next = q_head;
                    idx_next = '0;
                    if (q_head.run) begin
                        state_next = B_FETCH;
                    end else begin
                        out_next.status        = q_head.status;
                        out_next.id_byte       = q_head.id_byte;
                        out_next.size_field    = q_head.size_field;
                        out_next.stat_byte     = q_head.stat_byte;
                        out_next.content_byte  = '0;
                        out_next.content_index = '0;
                        out_next.has_content   = 1'b0;
                        out_next.last          = 1'b1;
                        state_next             = B_SEND;
                    end
                end
            end
            B_FETCH: begin
                state_next = B_LOAD;
            end
            B_LOAD: begin
                out_next.status        = ST_OK;
                out_next.id_byte       = job_reg.id_byte;
                out_next.size_field    = job_reg.size_field;
                out_next.stat_byte     = job_reg.stat_byte;
                out_next.content_byte  = ram_rdata;
                out_next.content_index = 6'(idx_reg);
                out_next.has_content   = 1'b1;
                out_next.last          = (8'(idx_reg) + 8'd1 == clen);
                state_next             = B_SEND;
            end
            B_SEND: begin
                if (m_ready) begin
                    if (out_reg.last) begin
                        run_done   = job_reg.run;
                        state_next = B_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_FETCH;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_fetch_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_FETCH |=> state_reg == B_LOAD) else $error("fetch not followed by load");
    a_content_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.has_content |-> m_data.status == ST_OK)
        else $error("content item with error status");
    a_load_run: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_LOAD |-> job_reg.run) else $error("store read without content run");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Testbench for the servo response frame receiver unit.
// ----------------------------------------------------------------------------
// Drives begin, byte and tick items into the receiver over a valid/ready
// channel, with both sides stalling at random. A scoreboard class keeps its
// own copy of the parser state and registers and predicts the result items
// for every accepted input item. Results are compared in order. The run
// covers directed corner frames, then random frames, both good and broken,
// under several register settings.
// ----------------------------------------------------------------------------
module tb;
    import srfr_pkg::*;

    localparam int MAX_FRAME = 64;
    localparam int LIMIT     = 400000;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef enum logic [2:0] {
        HUNT, GET_ID, GET_SIZE, GET_STAT, GET_CONTENT, GET_CHECK
    } rx_phase_t;

    class frame_scoreboard;
        logic [15:0] hdr_word;
        logic [7:0]  id_limit;
        logic [15:0] tick_limit;
        rx_phase_t   ph;
        bit          armed;
        bit          low_seen;
        logic [7:0]  f_id;
        logic [7:0]  f_size;
        logic [7:0]  f_stat;
        logic [7:0]  store [MAX_FRAME];
        int          n_content;
        logic [7:0]  csum;
        logic [15:0] ticks;
        out_item_t   expected_q[$];
        int          fails;

        function new();
            hdr_word   = 16'hFFFF;
            id_limit   = 8'd253;
            tick_limit = 16'd100;
            armed      = 0;
            fails      = 0;
            restart();
        endfunction

        function void restart();
            ph        = HUNT;
            low_seen  = 0;
            f_id      = '0;
            f_size    = '0;
            f_stat    = '0;
            n_content = 0;
            csum      = '0;
            ticks     = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                CFG_HEADER:  hdr_word   = val;
                CFG_MAX_ID:  id_limit   = val[7:0];
                CFG_TIMEOUT: tick_limit = val;
                default: ;
            endcase
        endfunction

        function void push(logic [2:0] st, logic [7:0] cb, logic [5:0] ci,
                           logic has, logic lst);
            out_item_t r;
            r.status        = st;
            r.id_byte       = f_id;
            r.size_field    = f_size;
            r.stat_byte     = f_stat;
            r.content_byte  = cb;
            r.content_index = ci;
            r.has_content   = has;
            r.last          = lst;
            expected_q.push_back(r);
        endfunction

        function void abort_frame(logic [2:0] st);
            push(st, 8'h00, 6'd0, 1'b0, 1'b1);
            armed = 0;
        endfunction

        function void parse_byte(logic [7:0] b);
            int clen;
            clen = int'(f_size) - 2;
            case (ph)
                HUNT: begin
                    if (!low_seen) begin
                        if (b == hdr_word[7:0]) low_seen = 1;
                    end else begin
                        low_seen = 0;
                        if (b == hdr_word[15:8]) ph = GET_ID;
                    end
                end
                GET_ID: begin
                    f_id = b;
                    if (b > id_limit) begin
                        abort_frame(ST_ID);
                    end else begin
                        csum = b;
                        ph   = GET_SIZE;
                    end
                end
                GET_SIZE: begin
                    f_size = b;
                    if (b < 8'd2 || int'(b) > MAX_FRAME - 5) begin
                        abort_frame(ST_SIZE);
                    end else begin
                        csum = csum + b;
                        ph   = GET_STAT;
                    end
                end
                GET_STAT: begin
                    f_stat    = b;
                    csum      = csum + b;
                    n_content = 0;
                    ph        = (f_size == 8'd2) ? GET_CHECK : GET_CONTENT;
                end
                GET_CONTENT: begin
                    if (n_content < MAX_FRAME) store[n_content] = b;
                    n_content++;
                    csum = csum + b;
                    if (n_content >= clen) ph = GET_CHECK;
                end
                GET_CHECK: begin
                    if (b != ~csum) begin
                        abort_frame(ST_CHECKSUM);
                    end else begin
                        armed = 0;
                        if (clen == 0) begin
                            push(ST_OK, 8'h00, 6'd0, 1'b0, 1'b1);
                        end else begin
                            for (int i = 0; i < clen && i < MAX_FRAME; i++)
                                push(ST_OK, store[i], 6'(i), 1'b1, i + 1 == clen);
                        end
                    end
                end
                default: begin
                    ph       = HUNT;
                    low_seen = 0;
                end
            endcase
        endfunction

        function void note_request(in_item_t it);
            case (it.req_type)
                REQ_BEGIN: begin
                    armed = 1;
                    restart();
                end
                REQ_BYTE: if (armed) parse_byte(it.rx_byte);
                REQ_TICK: begin
                    if (armed) begin
                        if (ticks != 16'hFFFF) ticks++;
                        if (ticks >= tick_limit) abort_frame(ST_TIMEOUT);
                    end
                end
                default: ;
            endcase
        endfunction

        function string show(out_item_t r);
            return $sformatf("st=%0d id=%h size=%h stat=%h byte=%h idx=%0d has=%b last=%b",
                             r.status, r.id_byte, r.size_field, r.stat_byte,
                             r.content_byte, r.content_index, r.has_content, r.last);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                if (fails < 10) $display("unexpected result: %s", show(got));
                fails++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                if (fails < 10) begin
                    $display("result mismatch");
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
                fails++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    frame_scoreboard sb;
    int s_idle_pct = 8;
    int m_idle_pct = 55;
    int items_sent = 0;
    int cycles     = 0;

    servo_response_frame_receiver_unit #(
        .MAX_FRAME(MAX_FRAME)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic put_item(logic [1:0] req, logic [7:0] b);
        in_item_t it;
        it.req_type = req;
        it.rx_byte  = b;
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(it);
        items_sent++;
    endtask

    // byte of a frame, now and then preceded by a tick
    task automatic put_byte(logic [7:0] b);
        if ($urandom_range(99) < 4) put_item(REQ_TICK, 8'($urandom));
        put_item(REQ_BYTE, b);
    endtask

    task automatic go_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_setting(int sel);
        logic [15:0] hdr;
        logic [7:0]  max_id;
        logic [15:0] tmo;
        case (sel)
            0: begin hdr = 16'hFFFF; max_id = 8'd253; tmo = 16'd100; end
            1: begin hdr = 16'h0000; max_id = 8'd255; tmo = 16'd1; end
            2: begin hdr = 16'hA55A; max_id = 8'd0;   tmo = 16'hFFFF; end
            3: begin
                hdr    = 16'($urandom_range(65535));
                max_id = 8'($urandom_range(255));
                tmo    = 16'($urandom_range(2, 20));
            end
            4: begin hdr = 16'hFFFF; max_id = 8'd128; tmo = 16'd30; end
            default: begin
                hdr    = 16'($urandom_range(65535));
                max_id = 8'($urandom_range(255));
                tmo    = 16'($urandom_range(1, 300));
            end
        endcase
        go_quiet();
        write_reg(CFG_HEADER, hdr);
        write_reg(CFG_MAX_ID, {8'h00, max_id});
        write_reg(CFG_TIMEOUT, tmo);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_frame();
        int          kind;
        int          clen;
        int          cut;
        int          n;
        logic [7:0]  id;
        logic [7:0]  size;
        logic [7:0]  stat;
        logic [7:0]  junk;
        logic [7:0]  sum;
        logic [7:0]  body [MAX_FRAME];
        kind = $urandom_range(99);
        if (kind < 6) begin
            repeat ($urandom_range(1, 4))
                put_item(2'($urandom_range(1, 3)), 8'($urandom));
            return;
        end
        put_item(REQ_BEGIN, 8'($urandom));
        if (kind < 14) begin
            put_byte(sb.hdr_word[7:0]);
            put_byte(sb.hdr_word[15:8]);
            if ($urandom_range(1)) put_byte(8'($urandom_range(0, sb.id_limit)));
            n = (sb.tick_limit <= 150) ? int'(sb.tick_limit) : 3;
            repeat (n) put_item(REQ_TICK, 8'($urandom));
            return;
        end
        if ($urandom_range(99) < 20) begin
            junk = 8'($urandom);
            if (junk == sb.hdr_word[7:0]) junk = ~junk;
            put_byte(junk);
        end
        put_byte(sb.hdr_word[7:0]);
        put_byte(sb.hdr_word[15:8]);
        if (kind < 22 && sb.id_limit != 8'hFF) begin
            put_byte(8'($urandom_range(int'(sb.id_limit) + 1, 255)));
            return;
        end
        id = 8'($urandom_range(0, sb.id_limit));
        put_byte(id);
        if (kind < 30) begin
            case ($urandom_range(2))
                0:       size = 8'd0;
                1:       size = 8'd1;
                default: size = 8'($urandom_range(MAX_FRAME - 4, 255));
            endcase
            put_byte(size);
            return;
        end
        n = $urandom_range(99);
        if (n < 5)       clen = MAX_FRAME - 7;
        else if (n < 15) clen = $urandom_range(0, MAX_FRAME - 7);
        else             clen = $urandom_range(0, 6);
        size = 8'(clen + 2);
        stat = 8'($urandom);
        sum  = id + size + stat;
        for (int i = 0; i < clen; i++) begin
            body[i] = 8'($urandom);
            sum     = sum + body[i];
        end
        cut = (kind < 36) ? $urandom_range(0, clen + 1) : clen + 2;
        put_byte(size);
        if (cut == 0) return;
        put_byte(stat);
        for (int i = 0; i < clen; i++) begin
            if (i + 1 >= cut) return;
            put_byte(body[i]);
        end
        if (cut <= clen) return;
        if (kind < 46) put_byte(~sum ^ 8'($urandom_range(1, 255)));
        else           put_byte(~sum);
    endtask

    initial begin
        int start;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // dropped while not armed, and the unused request code
        put_item(REQ_TICK, 8'h00);
        put_item(REQ_BYTE, 8'hFF);
        put_item(REQ_NONE, 8'hFF);
        // header high byte wrong, then id above the limit
        put_item(REQ_BEGIN, 8'h00);
        put_item(REQ_BYTE, 8'hFF);
        put_item(REQ_BYTE, 8'h00);
        put_item(REQ_BYTE, 8'hFF);
        put_item(REQ_BYTE, 8'hFF);
        put_item(REQ_BYTE, 8'd254);
        // size zero
        put_item(REQ_BEGIN, 8'hFF);
        put_item(REQ_BYTE, 8'hFF);
        put_item(REQ_BYTE, 8'hFF);
        put_item(REQ_BYTE, 8'd0);
        put_item(REQ_BYTE, 8'd0);
        // good frame without content
        put_item(REQ_BEGIN, 8'h00);
        put_item(REQ_BYTE, 8'hFF);
        put_item(REQ_BYTE, 8'hFF);
        put_item(REQ_BYTE, 8'd1);
        put_item(REQ_BYTE, 8'd2);
        put_item(REQ_BYTE, 8'hFF);
        put_item(REQ_BYTE, 8'hFD);
        // one content byte, bad checksum
        put_item(REQ_BEGIN, 8'h00);
        put_item(REQ_BYTE, 8'hFF);
        put_item(REQ_BYTE, 8'hFF);
        put_item(REQ_BYTE, 8'd253);
        put_item(REQ_BYTE, 8'd3);
        put_item(REQ_BYTE, 8'h80);
        put_item(REQ_BYTE, 8'hAA);
        put_item(REQ_BYTE, 8'h00);

        for (int sel = 0; sel < 6; sel++) begin
            case (sel / 2)
                0:       begin s_idle_pct = 8;  m_idle_pct = 55; end
                1:       begin s_idle_pct = 55; m_idle_pct = 8;  end
                default: begin s_idle_pct = 0;  m_idle_pct = 0;  end
            endcase
            apply_setting(sel);
            start = items_sent;
            while (items_sent - start < 20) random_frame();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
